### sv/dpae_pkg.sv
// Shared types and constants for the data-processing execute block.
// No dependencies.

package dpae_pkg;

	localparam int NUM_REGS_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed field widths of the stream payloads
	localparam int FUNC_W    = 4;
	localparam int REG_IDX_W = 4;
	localparam int OPND_W    = 12;
	localparam int RES_W     = 32;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 40;

	typedef enum logic [FUNC_W-1:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13
	} op_t;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
	} flags_t;

endpackage

### sv/data_processing_alu_exec_top.sv
// An accepted item is registered in stage 1 and is loaded into the output
// register when stage 1 advances; m_tvalid is that output register's valid bit.
// Throughput: one item per cycle unless the output stalls; the register-file
// write of one item and the next operand read meet at the same edge via a bypass.
// Reset (arst_n, async, active low) clears all register-file entries to zero
// through per-entry valid bits, clears N/Z/C, and empties both stages.
// Data-processing execute block: 16x32 register file, N/Z/C flags, one ALU pass.
// Depends on dpae_pkg.

module data_processing_alu_exec_top
	import dpae_pkg::*;
#(
	parameter int NUM_REGS   = NUM_REGS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [3:0] func, [4] set_flags, [8:5] first_reg, [12:9] dest_reg,
	// [24:13] operand_field, [31:25] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,   // [0] imm_select
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [31:0] result_value, [32] wrote_back, [33] flag_n, [34] flag_z,
	// [35] flag_c, [39:36] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tuser    // [0] illegal_op
);

	localparam int AW = $clog2(NUM_REGS);
	localparam int DW = DATA_WIDTH;

	// input field unpack
	logic [FUNC_W-1:0]    in_func;
	logic                 in_setf;
	logic [REG_IDX_W-1:0] in_rn, in_rd;
	logic [OPND_W-1:0]    in_opnd;
	assign in_func = s_tdata[3:0];
	assign in_setf = s_tdata[4];
	assign in_rn   = s_tdata[8:5];
	assign in_rd   = s_tdata[12:9];
	assign in_opnd = s_tdata[24:13];

	logic in_acc, adv_s1;
	logic vld_s1, vld_s2;

	assign adv_s1   = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv_s1;
	assign in_acc   = s_tvalid && s_tready;

	// register file storage
	logic [DW-1:0]       mem_q [NUM_REGS];
	logic [NUM_REGS-1:0] ent_vld_q;

	// stage 1
	logic [FUNC_W-1:0]    func_s1;
	logic                 imm_s1, setf_s1;
	logic [REG_IDX_W-1:0] rd_s1;
	logic [OPND_W-1:0]    opnd_s1;
	logic [DW-1:0]        a_mem_s1, b_mem_s1, byp_s1;
	logic                 a_ok_s1, b_ok_s1, a_byp_s1, b_byp_s1;

	// write-back of the item leaving stage 1
	logic          wr_en;
	logic [DW-1:0] res;
	logic          rn_in_range, rm_in_range;
	logic          fwd_a, fwd_b;

	assign rn_in_range = 32'(in_rn) < NUM_REGS;
	assign rm_in_range = 32'(in_opnd[3:0]) < NUM_REGS;
	assign fwd_a       = wr_en && (rd_s1 == in_rn);
	assign fwd_b       = wr_en && (rd_s1 == in_opnd[3:0]);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1  <= in_func;
			imm_s1   <= s_tuser;
			setf_s1  <= in_setf;
			rd_s1    <= in_rd;
			opnd_s1  <= in_opnd;
			a_mem_s1 <= mem_q[in_rn[AW-1:0]];
			b_mem_s1 <= mem_q[in_opnd[AW-1:0]];
			byp_s1   <= res;
		end
		if (wr_en) begin
			mem_q[rd_s1[AW-1:0]] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			a_ok_s1   <= 1'b0;
			b_ok_s1   <= 1'b0;
			a_byp_s1  <= 1'b0;
			b_byp_s1  <= 1'b0;
			ent_vld_q <= '0;
		end else begin
			if (in_acc) begin
				vld_s1   <= 1'b1;
				a_ok_s1  <= rn_in_range && (ent_vld_q[in_rn[AW-1:0]] || fwd_a);
				b_ok_s1  <= rm_in_range && (ent_vld_q[in_opnd[AW-1:0]] || fwd_b);
				a_byp_s1 <= fwd_a;
				b_byp_s1 <= fwd_b;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (wr_en) begin
				ent_vld_q[rd_s1[AW-1:0]] <= 1'b1;
			end
		end
	end

	// operands
	logic [DW-1:0] opa, rm_val, imm_rot, opb, imm_ext;
	logic [6:0]    rot_amt;

	assign opa    = !a_ok_s1 ? '0 : (a_byp_s1 ? byp_s1 : a_mem_s1);
	assign rm_val = !b_ok_s1 ? '0 : (b_byp_s1 ? byp_s1 : b_mem_s1);
	assign imm_ext = DW'(opnd_s1[7:0]);

	// twice the rotate field, reduced modulo the data width
	always_comb begin
		rot_amt = {2'b00, opnd_s1[11:8], 1'b0};
		for (int i = 0; i < 4; i++) begin
			if (rot_amt >= 7'(DW)) rot_amt = rot_amt - 7'(DW);
		end
	end

	// a shift by the full width yields zero, which covers a zero rotate
	assign imm_rot = (imm_ext >> rot_amt) | (imm_ext << (7'(DW) - rot_amt));
	assign opb     = imm_s1 ? imm_rot : rm_val;

	// ALU
	logic [DW:0] sum, dif_ab, dif_ba;
	logic        c_new, legal, writes;

	assign sum    = {1'b0, opa} + {1'b0, opb};
	assign dif_ab = {1'b0, opa} - {1'b0, opb};
	assign dif_ba = {1'b0, opb} - {1'b0, opa};

	always_comb begin
		res    = '0;
		c_new  = 1'b0;
		legal  = 1'b1;
		writes = 1'b1;
		case (op_t'(func_s1))
			OP_AND: res = opa & opb;
			OP_EOR: res = opa ^ opb;
			OP_SUB: begin
				res   = dif_ab[DW-1:0];
				c_new = !dif_ab[DW];
			end
			OP_RSB: begin
				res   = dif_ba[DW-1:0];
				c_new = !dif_ba[DW];
			end
			OP_ADD: begin
				res   = sum[DW-1:0];
				c_new = sum[DW];
			end
			OP_TST: begin
				res    = opa & opb;
				writes = 1'b0;
			end
			OP_TEQ: begin
				res    = opa ^ opb;
				writes = 1'b0;
			end
			OP_CMP: begin
				res    = dif_ab[DW-1:0];
				c_new  = !dif_ab[DW];
				writes = 1'b0;
			end
			OP_ORR: res = opa | opb;
			OP_MOV: res = opb;
			default: begin
				legal  = 1'b0;
				writes = 1'b0;
			end
		endcase
	end

	logic rd_in_range;
	assign rd_in_range = 32'(rd_s1) < NUM_REGS;
	assign wr_en       = adv_s1 && legal && writes && rd_in_range;

	// flags
	flags_t flags_q, flags_nx;

	always_comb begin
		flags_nx = flags_q;
		if (legal && setf_s1) begin
			flags_nx.n = res[DW-1];
			flags_nx.z = (res == '0);
			flags_nx.c = c_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (adv_s1) begin
			flags_q <= flags_nx;
		end
	end

	// output register
	logic [63:0]      res_ext;
	logic [RES_W-1:0] res_s2;
	logic             wrote_s2, illegal_s2;
	flags_t           flags_s2;

	assign res_ext = 64'(res);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2     <= res_ext[RES_W-1:0];
			wrote_s2   <= legal && writes && rd_in_range;
			flags_s2   <= flags_nx;
			illegal_s2 <= !legal;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {4'b0000, flags_s2.c, flags_s2.z, flags_s2.n, wrote_s2, res_s2};
	assign m_tuser  = illegal_s2;

	// checks
	a_illegal_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !legal) |=> $stable(flags_q))
		else $error("flags changed on an unsupported opcode");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (rd_in_range && legal && vld_s1))
		else $error("register write without a legal in-range item");

	a_wr_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> ent_vld_q[$past(rd_s1[AW-1:0])])
		else $error("written entry not marked valid");

endmodule

### tb/sv/data_processing_alu_exec_checker.sv
`timescale 1ns / 1ps
// Checker for the data-processing execute block: it watches both stream channels,
// predicts each result from its own register file and flags, and compares.
// Depends on dpae_pkg.

module data_processing_alu_exec_checker
	import dpae_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 m_tuser,
	output int                   mismatches,
	output int                   pending,
	output int                   instr_count,
	output int                   result_count,
	output int                   illegal_count,
	output int                   write_count
);

	typedef struct packed {
		logic [RES_W-1:0] value;
		logic             wrote;
		logic             n;
		logic             z;
		logic             c;
		logic             illegal;
	} exec_result_t;

	logic [RES_W-1:0] regfile [16];
	flags_t           flags;
	exec_result_t     expected_q [$];
	exec_result_t     want;

	initial begin
		mismatches    = 0;
		pending       = 0;
		instr_count   = 0;
		result_count  = 0;
		illegal_count = 0;
		write_count   = 0;
	end

	// imm8 rotated right by twice the 4-bit amount
	function automatic logic [31:0] rotated_imm(input logic [11:0] field);
		logic [63:0] twice;
		twice = {24'd0, field[7:0], 24'd0, field[7:0]};
		twice = twice >> {field[11:8], 1'b0};
		return twice[31:0];
	endfunction

	task automatic execute_instr(input logic [S_TDATA_W-1:0] word, input logic imm);
		op_t          op;
		logic         setf;
		logic [3:0]   rn;
		logic [3:0]   rd;
		logic [11:0]  field;
		logic [31:0]  a;
		logic [31:0]  b;
		logic [31:0]  r;
		logic [32:0]  wide;
		logic         carry;
		logic         legal;
		logic         writes;
		exec_result_t res;
		op     = op_t'(word[3:0]);
		setf   = word[4];
		rn     = word[8:5];
		rd     = word[12:9];
		field  = word[24:13];
		a      = regfile[rn];
		b      = imm ? rotated_imm(field) : regfile[field[3:0]];
		r      = '0;
		carry  = 1'b0;
		legal  = 1'b1;
		writes = 1'b1;
		case (op)
			OP_AND: r = a & b;
			OP_EOR: r = a ^ b;
			OP_SUB, OP_CMP: begin
				wide   = {1'b0, a} - {1'b0, b};
				r      = wide[31:0];
				carry  = !wide[32];
				writes = (op == OP_SUB);
			end
			OP_RSB: begin
				wide  = {1'b0, b} - {1'b0, a};
				r     = wide[31:0];
				carry = !wide[32];
			end
			OP_ADD: begin
				wide  = {1'b0, a} + {1'b0, b};
				r     = wide[31:0];
				carry = wide[32];
			end
			OP_TST: begin
				r      = a & b;
				writes = 1'b0;
			end
			OP_TEQ: begin
				r      = a ^ b;
				writes = 1'b0;
			end
			OP_ORR: r = a | b;
			OP_MOV: r = b;
			default: begin
				legal  = 1'b0;
				writes = 1'b0;
			end
		endcase
		// operands were read above, so rd == rn sees the old value
		if (writes) begin
			regfile[rd] = r;
			write_count++;
		end
		if (legal && setf) begin
			flags.n = r[31];
			flags.z = (r == '0);
			flags.c = carry;
		end
		if (!legal)
			illegal_count++;
		res.value   = r;
		res.wrote   = writes;
		res.n       = flags.n;
		res.z       = flags.z;
		res.c       = flags.c;
		res.illegal = !legal;
		expected_q.push_back(res);
		instr_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (regfile[i])
				regfile[i] = '0;
			flags = '0;
			expected_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected item: expected none, actual %h/%b",
						$time, m_tdata, m_tuser);
				end else begin
					want = expected_q.pop_front();
					check_field("result_value", want.value, m_tdata[31:0]);
					check_field("wrote_back", 32'(want.wrote), 32'(m_tdata[32]));
					check_field("flag_n", 32'(want.n), 32'(m_tdata[33]));
					check_field("flag_z", 32'(want.z), 32'(m_tdata[34]));
					check_field("flag_c", 32'(want.c), 32'(m_tdata[35]));
					check_field("illegal_op", 32'(want.illegal), 32'(m_tuser));
					result_count++;
				end
			end
			if (s_tvalid && s_tready)
				execute_instr(s_tdata, s_tuser);
		end
		pending = expected_q.size();
	end

endmodule

### tb/sv/data_processing_alu_exec_top_tb.sv
`timescale 1ns / 1ps
// Top of the execute-block testbench: clock, reset, instruction stimulus and
// output back-pressure. Depends on dpae_pkg, the block and its checker.

module data_processing_alu_exec_top_tb
	import dpae_pkg::*;
;

	localparam int RANDOM_ITEMS = 1100;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	int mismatches;
	int pending;
	int instr_count;
	int result_count;
	int illegal_count;
	int write_count;
	int sent_cnt;
	int cycles;
	bit held;

	data_processing_alu_exec_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	data_processing_alu_exec_checker exec_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.mismatches    (mismatches),
		.pending       (pending),
		.instr_count   (instr_count),
		.result_count  (result_count),
		.illegal_count (illegal_count),
		.write_count   (write_count)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("data_processing_alu_exec_top_tb: errors");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	task automatic send_instr(input logic [3:0] fn, input logic imm, input logic setf,
			input logic [3:0] rn, input logic [3:0] rd, input logic [11:0] field,
			input int unsigned gap);
		s_tdata  <= {7'd0, field, rd, rn, setf, fn};
		s_tuser  <= imm;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sent_cnt++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// receiver: random stalls, quiet windows, and one long hold-off to back up the block
	initial begin
		m_tready = 1'b0;
		held     = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && sent_cnt >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else if (((cycles >> 7) % 4) == 1 || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				repeat (gap_len() - 1) @(posedge clk);
			end
		end
	end

	initial begin
		op_t          op;
		logic [3:0]   fn;
		logic [3:0]   rn;
		logic [11:0]  field;
		int unsigned  gap;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		sent_cnt = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, back to back: rotations, carries, borrows, zero, read-before-write
		send_instr(OP_MOV, 1'b1, 1'b1, 4'd0, 4'd0, 12'h0FF, 0);
		send_instr(OP_MOV, 1'b1, 1'b1, 4'd0, 4'd1, 12'h1FF, 0);
		send_instr(OP_MOV, 1'b1, 1'b0, 4'd0, 4'd2, 12'hF80, 0);
		send_instr(OP_MOV, 1'b1, 1'b1, 4'd0, 4'd3, 12'h000, 0);
		send_instr(OP_ADD, 1'b0, 1'b1, 4'd1, 4'd4, 12'h001, 0);
		send_instr(OP_SUB, 1'b0, 1'b1, 4'd1, 4'd5, 12'hFF1, 0);
		send_instr(OP_RSB, 1'b1, 1'b1, 4'd1, 4'd6, 12'h4FF, 0);
		send_instr(OP_ADD, 1'b1, 1'b1, 4'd4, 4'd4, 12'hFFF, 0);
		send_instr(OP_MOV, 1'b1, 1'b0, 4'd0, 4'd13, 12'h8AB, 0);
		send_instr(OP_ADD, 1'b0, 1'b1, 4'd13, 4'd13, 12'h00D, 0);
		send_instr(OP_ADD, 1'b0, 1'b0, 4'd15, 4'd15, 12'h00F, 0);
		// every opcode code, defined or not, against r1 and r0
		for (int k = 0; k < 16; k++)
			send_instr(k[3:0], 1'b0, 1'b1, 4'd1, 4'd7 + k[3:0], 12'hA50, 0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				fn = 4'($urandom_range(0, 15));
			end else begin
				op = op.first();
				repeat ($urandom_range(0, op.num() - 1)) op = op.next();
				fn = op;
			end
			rn    = 4'($urandom_range(0, 15));
			field = 12'($urandom_range(0, 4095));
			// same register on both sides: zero results, equal compares
			if ($urandom_range(0, 7) == 0)
				field[3:0] = rn;
			if (((cycles >> 7) % 5) == 2 || $urandom_range(0, 1) == 0)
				gap = 0;
			else
				gap = gap_len();
			send_instr(fn, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rn,
				4'($urandom_range(0, 15)), field, gap);
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d instructions executed (%0d undefined opcodes, %0d register writes),",
			instr_count, illegal_count, write_count);
		$display("%0d results checked; output held off for %0d cycles once.",
			result_count, HOLD_CYCLES);
		if (mismatches == 0)
			$display("data_processing_alu_exec_top_tb: clean");
		else
			$display("data_processing_alu_exec_top_tb: errors");
		$finish;
	end

endmodule

### files.f
sv/dpae_pkg.sv
sv/data_processing_alu_exec_top.sv
tb/sv/data_processing_alu_exec_checker.sv
tb/sv/data_processing_alu_exec_top_tb.sv
